>>> hw/rtl/qmr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the quaternion multiply and renormalize core.
package qmr_pkg;

   localparam int FracBits = 14;
   localparam int CompW    = 16;
   localparam int CountW   = 6;
   localparam int ThrW     = 5;
   localparam int Lanes    = 4;

   localparam int LaneX = 0;
   localparam int LaneY = 1;
   localparam int LaneZ = 2;
   localparam int LaneW = 3;

   localparam logic [ThrW-1:0]   ThrReset = 5'd10;
   localparam logic [CountW-1:0] CountMax = '1;

   localparam logic signed [CompW-1:0] CompMax = {1'b0, {(CompW-1){1'b1}}};
   localparam logic signed [CompW-1:0] CompMin = {1'b1, {(CompW-1){1'b0}}};

   typedef struct packed {
      logic              norm;
      logic [CountW-1:0] count;
   } meta_type;

endpackage

>>> hw/rtl/qmr_req_if.sv
`timescale 1ns / 1ps
// Input channel: two quaternions and their product counts.
interface qmr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] a_x;
   logic signed [15:0] a_y;
   logic signed [15:0] a_z;
   logic signed [15:0] a_w;
   logic signed [15:0] b_x;
   logic signed [15:0] b_y;
   logic signed [15:0] b_z;
   logic signed [15:0] b_w;
   logic [5:0]         a_count;
   logic [5:0]         b_count;

   modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, a_count, b_count,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, a_count, b_count,
                 output ready);
endinterface

>>> hw/rtl/qmr_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: product quaternion, new count and degenerate flag.
interface qmr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] r_x;
   logic signed [15:0] r_y;
   logic signed [15:0] r_z;
   logic signed [15:0] r_w;
   logic [5:0]         r_count;
   logic               degenerate;

   modport source (output valid, r_x, r_y, r_z, r_w, r_count, degenerate, input ready);
   modport sink (input valid, r_x, r_y, r_z, r_w, r_count, degenerate, output ready);
endinterface

>>> hw/rtl/qmr_product.sv
`timescale 1ns / 1ps
// Hamilton product: sixteen multiplies, then signed sums with rounding, plus count update.
module qmr_product #(
   parameter int FRAC_BITS = qmr_pkg::FracBits
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic signed [qmr_pkg::CompW-1:0] a_in [qmr_pkg::Lanes],
   input  logic signed [qmr_pkg::CompW-1:0] b_in [qmr_pkg::Lanes],
   input  logic [qmr_pkg::CountW-1:0]      a_count,
   input  logic [qmr_pkg::CountW-1:0]      b_count,
   input  logic [qmr_pkg::ThrW-1:0]        threshold,
   output logic                            out_valid,
   output logic signed [33-FRAC_BITS:0]    p_out [qmr_pkg::Lanes],
   output qmr_pkg::meta_type               meta_out
);
   import qmr_pkg::*;

   localparam int ProdW = 2 * CompW;
   localparam int SumW  = ProdW + 2;
   localparam int PW    = SumW - FRAC_BITS;
   localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (FRAC_BITS - 1);

   logic signed [ProdW-1:0] prod_in [Lanes][Lanes];
   logic signed [ProdW-1:0] prod_ff [Lanes][Lanes];
   logic [CountW:0]         cnt_in, cnt_ff;
   logic                    vld1_ff;

   logic signed [SumW-1:0]  sum_c [Lanes];
   logic signed [PW-1:0]    p_in  [Lanes];
   logic signed [PW-1:0]    p_ff  [Lanes];
   meta_type                meta_in, meta_ff;
   logic                    vld2_ff;

   always_comb begin
      prod_in[LaneX][0] = a_in[LaneW] * b_in[LaneX];
      prod_in[LaneX][1] = a_in[LaneX] * b_in[LaneW];
      prod_in[LaneX][2] = a_in[LaneY] * b_in[LaneZ];
      prod_in[LaneX][3] = a_in[LaneZ] * b_in[LaneY];
      prod_in[LaneY][0] = a_in[LaneW] * b_in[LaneY];
      prod_in[LaneY][1] = a_in[LaneY] * b_in[LaneW];
      prod_in[LaneY][2] = a_in[LaneZ] * b_in[LaneX];
      prod_in[LaneY][3] = a_in[LaneX] * b_in[LaneZ];
      prod_in[LaneZ][0] = a_in[LaneW] * b_in[LaneZ];
      prod_in[LaneZ][1] = a_in[LaneZ] * b_in[LaneW];
      prod_in[LaneZ][2] = a_in[LaneX] * b_in[LaneY];
      prod_in[LaneZ][3] = a_in[LaneY] * b_in[LaneX];
      prod_in[LaneW][0] = a_in[LaneW] * b_in[LaneW];
      prod_in[LaneW][1] = a_in[LaneX] * b_in[LaneX];
      prod_in[LaneW][2] = a_in[LaneY] * b_in[LaneY];
      prod_in[LaneW][3] = a_in[LaneZ] * b_in[LaneZ];
      cnt_in = {1'b0, a_count} + {1'b0, b_count} + (CountW+1)'(1);
   end

   always_comb begin
      // vector lanes: three added, last subtracted; scalar lane: first added, rest subtracted
      for (int l = 0; l < LaneW; l++) begin
         sum_c[l] = SumW'(prod_ff[l][0]) + SumW'(prod_ff[l][1]) + SumW'(prod_ff[l][2])
                  - SumW'(prod_ff[l][3]);
      end
      sum_c[LaneW] = SumW'(prod_ff[LaneW][0]) - SumW'(prod_ff[LaneW][1])
                   - SumW'(prod_ff[LaneW][2]) - SumW'(prod_ff[LaneW][3]);
      for (int l = 0; l < Lanes; l++) begin
         p_in[l] = PW'((sum_c[l] + Half) >>> FRAC_BITS);
      end
      meta_in.norm  = cnt_ff > (CountW+1)'(threshold);
      meta_in.count = cnt_ff[CountW] ? CountMax : cnt_ff[CountW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         cnt_ff  <= cnt_in;
         p_ff    <= p_in;
         meta_ff <= meta_in;
      end
   end

   assign out_valid = vld2_ff;
   assign p_out     = p_ff;
   assign meta_out  = meta_ff;

endmodule

>>> hw/rtl/qmr_isqrt.sv
`timescale 1ns / 1ps
// Magnitude: squares, sum, then one square root digit per pipeline stage.
module qmr_isqrt #(
   parameter int FRAC_BITS = qmr_pkg::FracBits
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [33-FRAC_BITS:0] p_in [qmr_pkg::Lanes],
   input  qmr_pkg::meta_type            meta_in,
   output logic                         out_valid,
   output logic signed [33-FRAC_BITS:0] p_out [qmr_pkg::Lanes],
   output logic [33-FRAC_BITS:0]        mag_out,
   output qmr_pkg::meta_type            meta_out
);
   import qmr_pkg::*;

   localparam int PW  = 34 - FRAC_BITS;
   localparam int SW  = 2 * PW;
   localparam int NSQ = PW;
   localparam logic [SW-1:0] One = SW'(1);

   logic signed [SW-1:0] sq_c [Lanes];
   logic [SW-1:0]        sq_ff [Lanes];
   logic signed [PW-1:0] psq_ff [Lanes];
   meta_type             msq_ff;
   logic                 vsq_ff;

   logic [SW-1:0]        rem_ff [NSQ+1];
   logic [SW-1:0]        res_ff [NSQ+1];
   logic signed [PW-1:0] p_ff   [NSQ+1][Lanes];
   meta_type             meta_ff [NSQ+1];
   logic                 vld_ff [NSQ+1];

   logic [SW-1:0]        rem_in [NSQ];
   logic [SW-1:0]        res_in [NSQ];
   logic [SW-1:0]        trial_c [NSQ];
   logic [SW-1:0]        sum_c;

   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         sq_c[l] = p_in[l] * p_in[l];
      end
      sum_c = sq_ff[0] + sq_ff[1] + sq_ff[2] + sq_ff[3];
      for (int i = 0; i < NSQ; i++) begin
         trial_c[i] = res_ff[i] + (One << (SW - 2 - 2 * i));
         if (rem_ff[i] >= trial_c[i]) begin
            rem_in[i] = rem_ff[i] - trial_c[i];
            res_in[i] = (res_ff[i] >> 1) + (One << (SW - 2 - 2 * i));
         end else begin
            rem_in[i] = rem_ff[i];
            res_in[i] = res_ff[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vsq_ff <= 1'b0;
         for (int i = 0; i <= NSQ; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vsq_ff    <= in_valid;
         vld_ff[0] <= vsq_ff;
         for (int i = 0; i < NSQ; i++) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < Lanes; l++) begin
            sq_ff[l] <= $unsigned(sq_c[l]);
         end
         psq_ff     <= p_in;
         msq_ff     <= meta_in;
         rem_ff[0]  <= sum_c;
         res_ff[0]  <= '0;
         p_ff[0]    <= psq_ff;
         meta_ff[0] <= msq_ff;
         for (int i = 0; i < NSQ; i++) begin
            rem_ff[i+1]  <= rem_in[i];
            res_ff[i+1]  <= res_in[i];
            p_ff[i+1]    <= p_ff[i];
            meta_ff[i+1] <= meta_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[NSQ];
   assign p_out     = p_ff[NSQ];
   assign mag_out   = res_ff[NSQ][PW-1:0];
   assign meta_out  = meta_ff[NSQ];

endmodule

>>> hw/rtl/qmr_scale.sv
`timescale 1ns / 1ps
// Scaling: restoring division of each lane by the magnitude, one quotient bit per stage.
module qmr_scale #(
   parameter int FRAC_BITS = qmr_pkg::FracBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [33-FRAC_BITS:0]     p_in [qmr_pkg::Lanes],
   input  logic [33-FRAC_BITS:0]            mag_in,
   input  qmr_pkg::meta_type                meta_in,
   output logic                             out_valid,
   output logic signed [qmr_pkg::CompW-1:0] r_out [qmr_pkg::Lanes],
   output logic [qmr_pkg::CountW-1:0]       count_out,
   output logic                             deg_out
);
   import qmr_pkg::*;

   localparam int PW   = 34 - FRAC_BITS;
   localparam int SumW = 34;
   localparam int DW   = PW + 1;
   localparam int QW   = CompW + 1;
   localparam int NW   = PW + FRAC_BITS + 2;
   localparam int WIDE = (NW > DW + QW - 1) ? NW : DW + QW - 1;

   logic [WIDE-1:0]         rem_ff [QW+1][Lanes];
   logic [QW-1:0]           q_ff   [QW+1][Lanes];
   logic                    neg_ff [QW+1][Lanes];
   logic signed [CompW-1:0] dir_ff [QW+1][Lanes];
   logic [DW-1:0]           d_ff   [QW+1];
   meta_type                meta_ff [QW+1];
   logic                    deg_ff [QW+1];
   logic                    vld_ff [QW+1];

   logic [WIDE-1:0]         rem_in [QW][Lanes];
   logic [QW-1:0]           q_in   [QW][Lanes];
   logic [WIDE-1:0]         shd_c  [QW];

   logic [PW-1:0]           mag_c  [Lanes];
   logic                    neg_c  [Lanes];
   logic signed [SumW-1:0]  pe_c   [Lanes];
   logic [WIDE-1:0]         num_c  [Lanes];
   logic signed [CompW-1:0] dir_c  [Lanes];

   logic signed [CompW-1:0] r_in  [Lanes];
   logic signed [CompW-1:0] r_ff  [Lanes];
   logic [CountW-1:0]       cnt_in, cnt_ff;
   logic                    dego_in, dego_ff, vout_ff;

   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         neg_c[l] = p_in[l][PW-1];
         mag_c[l] = neg_c[l] ? $unsigned(-p_in[l]) : $unsigned(p_in[l]);
         num_c[l] = (WIDE'(mag_c[l]) << (FRAC_BITS + 1)) + WIDE'(mag_in);
         pe_c[l]  = p_in[l];
         if (pe_c[l] > SumW'(CompMax)) begin
            dir_c[l] = CompMax;
         end else if (pe_c[l] < SumW'(CompMin)) begin
            dir_c[l] = CompMin;
         end else begin
            dir_c[l] = pe_c[l][CompW-1:0];
         end
      end
      for (int t = 0; t < QW; t++) begin
         shd_c[t] = WIDE'(d_ff[t]) << (QW - 1 - t);
         for (int l = 0; l < Lanes; l++) begin
            q_in[t][l] = q_ff[t][l];
            if (rem_ff[t][l] >= shd_c[t]) begin
               rem_in[t][l] = rem_ff[t][l] - shd_c[t];
               q_in[t][l][QW-1-t] = 1'b1;
            end else begin
               rem_in[t][l] = rem_ff[t][l];
            end
         end
      end
   end

   // quotient at or above 2^15 saturates to the rail of its sign
   always_comb begin
      for (int l = 0; l < Lanes; l++) begin
         if (!meta_ff[QW].norm) begin
            r_in[l] = dir_ff[QW][l];
         end else if (deg_ff[QW]) begin
            r_in[l] = '0;
         end else if (q_ff[QW][l][QW-1] || q_ff[QW][l][QW-2]) begin
            r_in[l] = neg_ff[QW][l] ? CompMin : CompMax;
         end else if (neg_ff[QW][l]) begin
            r_in[l] = -$signed(q_ff[QW][l][CompW-1:0]);
         end else begin
            r_in[l] = $signed(q_ff[QW][l][CompW-1:0]);
         end
      end
      cnt_in  = meta_ff[QW].norm ? '0 : meta_ff[QW].count;
      dego_in = meta_ff[QW].norm & deg_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
         for (int t = 0; t <= QW; t++) begin
            vld_ff[t] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int t = 0; t < QW; t++) begin
            vld_ff[t+1] <= vld_ff[t];
         end
         vout_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < Lanes; l++) begin
            rem_ff[0][l] <= num_c[l];
            q_ff[0][l]   <= '0;
            neg_ff[0][l] <= neg_c[l];
            dir_ff[0][l] <= dir_c[l];
         end
         d_ff[0]    <= {mag_in, 1'b0};
         meta_ff[0] <= meta_in;
         deg_ff[0]  <= (mag_in == '0);
         for (int t = 0; t < QW; t++) begin
            rem_ff[t+1]  <= rem_in[t];
            q_ff[t+1]    <= q_in[t];
            neg_ff[t+1]  <= neg_ff[t];
            dir_ff[t+1]  <= dir_ff[t];
            d_ff[t+1]    <= d_ff[t];
            meta_ff[t+1] <= meta_ff[t];
            deg_ff[t+1]  <= deg_ff[t];
         end
         r_ff    <= r_in;
         cnt_ff  <= cnt_in;
         dego_ff <= dego_in;
      end
   end

   assign out_valid = vout_ff;
   assign r_out     = r_ff;
   assign count_out = cnt_ff;
   assign deg_out   = dego_ff;

endmodule

>>> hw/rtl/quat_multiply_renormalize_core.sv
`timescale 1ns / 1ps
// Top level: quaternion Hamilton product with threshold-driven renormalization.
//
//   channel   direction  handshake        payload
//   req_if    in         valid / ready    a_x a_y a_z a_w b_x b_y b_z b_w a_count b_count
//   rsp_if    out        valid / ready    r_x r_y r_z r_w r_count degenerate
//   csr_*     in         csr_we           csr_wdata = renorm_threshold
//
// One item enters per cycle while the pipe is not held; the pipe has one square root stage
// per result bit and one division stage per quotient bit.
// Reset clears the valid bits of every stage and loads the threshold with 10.
// The whole pipe holds when the output register is full and rsp_if.ready is low;
// the input is refused while it holds, even with bubbles inside the pipe.
module quat_multiply_renormalize_core #(
   parameter int FRAC_BITS = qmr_pkg::FracBits
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [qmr_pkg::ThrW-1:0]   csr_wdata,
   qmr_req_if.sink                    req_if,
   qmr_rsp_if.source                  rsp_if
);
   import qmr_pkg::*;

   localparam int PW = 34 - FRAC_BITS;

   logic [ThrW-1:0]         thr_ff, thr_in;
   logic                    en;

   logic signed [CompW-1:0] a_vec [Lanes];
   logic signed [CompW-1:0] b_vec [Lanes];

   logic                    prod_vld;
   logic signed [PW-1:0]    prod_p [Lanes];
   meta_type                prod_meta;

   logic                    sq_vld;
   logic signed [PW-1:0]    sq_p [Lanes];
   logic [PW-1:0]           sq_mag;
   meta_type                sq_meta;

   logic signed [CompW-1:0] r_vec [Lanes];

   assign thr_in = csr_we ? csr_wdata : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrReset;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // advance everything unless a finished item is stuck at the output
   assign en           = rsp_if.ready | ~rsp_if.valid;
   assign req_if.ready = en;

   assign a_vec[LaneX] = req_if.a_x;
   assign a_vec[LaneY] = req_if.a_y;
   assign a_vec[LaneZ] = req_if.a_z;
   assign a_vec[LaneW] = req_if.a_w;
   assign b_vec[LaneX] = req_if.b_x;
   assign b_vec[LaneY] = req_if.b_y;
   assign b_vec[LaneZ] = req_if.b_z;
   assign b_vec[LaneW] = req_if.b_w;

   qmr_product #(.FRAC_BITS(FRAC_BITS)) u_product (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_if.valid),
      .a_in      (a_vec),
      .b_in      (b_vec),
      .a_count   (req_if.a_count),
      .b_count   (req_if.b_count),
      .threshold (thr_ff),
      .out_valid (prod_vld),
      .p_out     (prod_p),
      .meta_out  (prod_meta)
   );

   qmr_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prod_vld),
      .p_in      (prod_p),
      .meta_in   (prod_meta),
      .out_valid (sq_vld),
      .p_out     (sq_p),
      .mag_out   (sq_mag),
      .meta_out  (sq_meta)
   );

   qmr_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .p_in      (sq_p),
      .mag_in    (sq_mag),
      .meta_in   (sq_meta),
      .out_valid (rsp_if.valid),
      .r_out     (r_vec),
      .count_out (rsp_if.r_count),
      .deg_out   (rsp_if.degenerate)
   );

   assign rsp_if.r_x = r_vec[LaneX];
   assign rsp_if.r_y = r_vec[LaneY];
   assign rsp_if.r_z = r_vec[LaneZ];
   assign rsp_if.r_w = r_vec[LaneW];

`ifndef ASSERT_OFF
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("input taken while output item is stalled");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.degenerate |->
         (rsp_if.r_x == '0 && rsp_if.r_y == '0 && rsp_if.r_z == '0 &&
          rsp_if.r_w == '0 && rsp_if.r_count == '0))
      else $error("degenerate item with nonzero fields");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("output valid right after reset");
`endif

endmodule

>>> tb/quat_multiply_renormalize_core_test.sv
`timescale 1ns / 1ps
// Testbench for the quaternion multiply and renormalize core: directed, threshold and random tests.
module quat_multiply_renormalize_core_test;
   import qmr_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 60;

   typedef struct {
      logic signed [CompW-1:0] x, y, z, w;
      logic [CountW-1:0]       count;
      logic                    degenerate;
   } product_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [ThrW-1:0] csr_wdata = '0;

   qmr_req_if req_if ();
   qmr_rsp_if rsp_if ();

   quat_multiply_renormalize_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_if   (req_if),
      .rsp_if   (rsp_if)
   );

   always #5 clock = ~clock;

   logic [ThrW-1:0] model_threshold = ThrReset;
   product_type     pending_products[$];
   int              error_count = 0;
   int              cycle_count = 0;
   bit              rsp_no_stall = 1'b0;
   bit              req_no_gap = 1'b0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t timeout", $realtime);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint sat_comp(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Round to nearest, ties away from zero; cap the magnitude before saturation.
   function automatic longint scale_to_unit(longint p, longint unsigned m);
      longint unsigned mag;
      longint unsigned q;
      mag = (p < 0) ? -p : p;
      q = ((mag << (FracBits + 1)) + m) / (2 * m);
      if (q > 65536) q = 65536;
      return (p < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic product_type hamilton_product(
      longint ax, longint ay, longint az, longint aw,
      longint bx, longint by, longint bz, longint bw,
      int ac, int bc);
      longint half;
      longint p[4];
      longint unsigned s;
      longint unsigned m;
      int count;
      longint r[4];
      product_type res;
      half = longint'(1) << (FracBits - 1);
      p[0] = (aw * bx + ax * bw + ay * bz - az * by + half) >>> FracBits;
      p[1] = (aw * by + ay * bw + az * bx - ax * bz + half) >>> FracBits;
      p[2] = (aw * bz + az * bw + ax * by - ay * bx + half) >>> FracBits;
      p[3] = (aw * bw - ax * bx - ay * by - az * bz + half) >>> FracBits;
      count = ac + bc + 1;
      res.degenerate = 1'b0;
      if (count > model_threshold) begin
         s = 0;
         for (int i = 0; i < 4; i++) s += p[i] * p[i];
         m = int_sqrt(s);
         for (int i = 0; i < 4; i++) r[i] = (m == 0) ? 0 : sat_comp(scale_to_unit(p[i], m));
         res.degenerate = (m == 0);
         count = 0;
      end else begin
         for (int i = 0; i < 4; i++) r[i] = sat_comp(p[i]);
         if (count > 63) count = 63;
      end
      res.x = CompW'(r[0]);
      res.y = CompW'(r[1]);
      res.z = CompW'(r[2]);
      res.w = CompW'(r[3]);
      res.count = CountW'(count);
      return res;
   endfunction

   task automatic send_pair(logic signed [15:0] ax, ay, az, aw, bx, by, bz, bw,
                            logic [5:0] ac, bc);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.a_x <= ax; req_if.a_y <= ay; req_if.a_z <= az; req_if.a_w <= aw;
      req_if.b_x <= bx; req_if.b_y <= by; req_if.b_z <= bz; req_if.b_w <= bw;
      req_if.a_count <= ac;
      req_if.b_count <= bc;
      do @(posedge clock); while (!req_if.ready);
      pending_products.push_back(hamilton_product(ax, ay, az, aw, bx, by, bz, bw, ac, bc));
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_threshold(logic [ThrW-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_threshold = value;
   endtask

   task automatic send_random_pair();
      logic signed [15:0] c[8];
      logic [5:0] ac, bc;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) begin
         if (kind < 6) c[i] = 16'($urandom);
         else if (kind < 8) c[i] = 16'($signed($urandom_range(0, 8)) - 4);
         else c[i] = ($urandom_range(0, 1) != 0) ? CompMax : CompMin;
      end
      // Favor small counts so both the plain and the normalizing path are hit.
      if ($urandom_range(0, 3) == 0) begin
         ac = 6'($urandom);
         bc = 6'($urandom);
      end else begin
         ac = 6'($urandom_range(0, 12));
         bc = 6'($urandom_range(0, 12));
      end
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], ac, bc);
   endtask

   task automatic test_directed();
      // zero quaternions, with and without normalization
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 63, 63);
      // unit times unit
      send_pair(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0);
      send_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 5, 5);
      send_pair(0, 0, 16384, 0, 0, 0, 0, 16384, 10, 0);
      // saturation without normalization, then with it
      send_pair(CompMin, CompMin, CompMin, CompMin, CompMin, CompMin, CompMin, CompMin, 0, 0);
      send_pair(CompMax, CompMax, CompMax, CompMax, CompMax, CompMax, CompMax, CompMax, 0, 0);
      send_pair(CompMax, CompMin, CompMax, CompMin, CompMin, CompMax, CompMin, CompMax, 4, 5);
      send_pair(CompMin, CompMin, CompMin, CompMin, CompMin, CompMin, CompMin, CompMin, 63, 0);
      send_pair(CompMax, CompMax, CompMax, CompMax, CompMax, CompMax, CompMax, CompMax, 0, 63);
      // tiny products that round to zero: degenerate on normalization
      send_pair(1, -1, 1, -1, 1, 1, -1, -1, 11, 0);
      send_pair(-1, 0, 0, 0, 1, 0, 0, 0, 6, 6);
      // count at and just above the default threshold, then both input counts at maximum
      send_pair(100, 200, -300, 400, -50, 60, 70, -80, 9, 0);
      send_pair(100, 200, -300, 400, -50, 60, 70, -80, 10, 0);
      send_pair(8192, -8192, 8192, -8192, 8192, 8192, -8192, 8192, 63, 63);
   endtask

   task automatic test_thresholds();
      write_threshold('0);
      repeat (10) send_random_pair();
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      write_threshold('1);
      repeat (10) send_random_pair();
      send_pair(3, 3, 3, 3, 3, 3, 3, 3, 31, 0);
      write_threshold(5'($urandom_range(1, 30)));
      repeat (10) send_random_pair();
      write_threshold(ThrReset);
   endtask

   task automatic test_random();
      for (int n = 0; n < 400; n++) begin
         if (n % 80 == 0) begin
            req_no_gap = ($urandom_range(0, 2) == 0);
            rsp_no_stall = ($urandom_range(0, 2) == 0);
         end
         // hold off once until the pipe is empty
         if (n == 200) wait_drained();
         if (n == 300) write_threshold(5'($urandom_range(0, 31)));
         send_random_pair();
      end
   endtask

   // Response side: random stall before each item, with stall-free stretches.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = rsp_no_stall ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   always @(posedge clock) begin
      product_type exp_p;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_products.size() == 0) begin
            $display("%0t unexpected item: x=%0d y=%0d z=%0d w=%0d count=%0d degenerate=%0b",
                     $realtime, rsp_if.r_x, rsp_if.r_y, rsp_if.r_z, rsp_if.r_w,
                     rsp_if.r_count, rsp_if.degenerate);
            error_count++;
         end else begin
            exp_p = pending_products.pop_front();
            if (rsp_if.r_x !== exp_p.x || rsp_if.r_y !== exp_p.y || rsp_if.r_z !== exp_p.z ||
                rsp_if.r_w !== exp_p.w || rsp_if.r_count !== exp_p.count ||
                rsp_if.degenerate !== exp_p.degenerate) begin
               $display("%0t mismatch: expected x=%0d y=%0d z=%0d w=%0d count=%0d deg=%0b",
                        $realtime, exp_p.x, exp_p.y, exp_p.z, exp_p.w, exp_p.count,
                        exp_p.degenerate);
               $display("%0t           actual x=%0d y=%0d z=%0d w=%0d count=%0d deg=%0b",
                        $realtime, rsp_if.r_x, rsp_if.r_y, rsp_if.r_z, rsp_if.r_w,
                        rsp_if.r_count, rsp_if.degenerate);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      {req_if.a_x, req_if.a_y, req_if.a_z, req_if.a_w} = '0;
      {req_if.b_x, req_if.b_y, req_if.b_z, req_if.b_w} = '0;
      req_if.a_count = '0;
      req_if.b_count = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_thresholds();
      test_random();
      wait_drained();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/qmr_pkg.sv
hw/rtl/qmr_req_if.sv
hw/rtl/qmr_rsp_if.sv
hw/rtl/qmr_product.sv
hw/rtl/qmr_isqrt.sv
hw/rtl/qmr_scale.sv
hw/rtl/quat_multiply_renormalize_core.sv
tb/quat_multiply_renormalize_core_test.sv
